[sv/complex_arithmetic_unit_assert.svh]
// ---------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cau_pkg.sv]
// ---------------------------------------------------------------------------
// cau_pkg
// operation codes, pipeline constants and stage payload types
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  localparam int CAU_DIV_STEPS = 33;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        neg;
    logic        big;
    logic [63:0] rem;
    logic [32:0] lo;
    logic [32:0] q;
  } cau_lane_t;

  typedef struct packed {
    logic [31:0] fix_re;
    logic [31:0] fix_im;
    logic        fix_eq;
    logic        fix_dz;
    logic        fix_ovf;
    logic        use_div;
    logic        use_sqrt;
    logic [63:0] den;
    cau_lane_t   re;
    cau_lane_t   im;
    logic [65:0] sq_src;
    logic [35:0] sq_rem;
    logic [31:0] sq_root;
  } cau_work_t;

endpackage

[sv/cau_front.sv]
// ---------------------------------------------------------------------------
// cau_front
// operand capture, products, sums and divider / root setup (four stages)
// ---------------------------------------------------------------------------
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               work_vld,
  output cau_pkg::cau_work_t work
);
  import cau_pkg::*;

  localparam int HI_SHIFT = 33 - FRAC_BITS;

  function automatic logic [32:0] sat_wide(input logic [64:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[64:31];
    all_zero = ~|v[64:31];
    if (all_one || all_zero) return {1'b0, v[31:0]};
    else if (v[64]) return {1'b1, SAT_MIN};
    else return {1'b1, SAT_MAX};
  endfunction

  function automatic cau_lane_t lane_init(input logic [64:0] v, input logic [63:0] den);
    cau_lane_t   l;
    logic [64:0] mag;
    mag    = v[64] ? (~v + 65'd1) : v;
    l.neg  = v[64];
    l.rem  = mag[63:0] >> HI_SHIFT;
    l.big  = (l.rem >= den);
    l.lo   = 33'({mag[63:0], {FRAC_BITS{1'b0}}});
    l.q    = '0;
    return l;
  endfunction

  // stage 0
  logic               v0_r;
  logic [2:0]         op0_r;
  logic signed [31:0] ar0_r, ai0_r, br0_r, bi0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
  end

  always_ff @(posedge clk) begin
    op0_r <= op;
    ar0_r <= a_re;
    ai0_r <= a_im;
    br0_r <= b_re;
    bi0_r <= b_im;
  end

  // stage 1
  logic signed [31:0] sq_x, sq_y;
  logic [32:0]        add_re, add_im;
  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, q0_r, q1_r;
  logic [32:0]        add_re1_r, add_im1_r;
  logic               eq1_r;

  assign sq_x   = (op0_r == OP_MAG) ? ar0_r : br0_r;
  assign sq_y   = (op0_r == OP_MAG) ? ai0_r : bi0_r;
  assign add_re = (op0_r == OP_SUB) ? ({ar0_r[31], ar0_r} - {br0_r[31], br0_r})
                                    : ({ar0_r[31], ar0_r} + {br0_r[31], br0_r});
  assign add_im = (op0_r == OP_SUB) ? ({ai0_r[31], ai0_r} - {bi0_r[31], bi0_r})
                                    : ({ai0_r[31], ai0_r} + {bi0_r[31], bi0_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    op1_r     <= op0_r;
    p0_r      <= ar0_r * br0_r;
    p1_r      <= ai0_r * bi0_r;
    p2_r      <= ar0_r * bi0_r;
    p3_r      <= ai0_r * br0_r;
    q0_r      <= sq_x * sq_x;
    q1_r      <= sq_y * sq_y;
    add_re1_r <= add_re;
    add_im1_r <= add_im;
    eq1_r     <= (ar0_r == br0_r) && (ai0_r == bi0_r);
  end

  // stage 2
  logic [64:0] sre_nxt, sim_nxt;
  logic        v2_r;
  logic [2:0]  op2_r;
  logic [64:0] sre2_r, sim2_r;
  logic [63:0] ssq2_r;
  logic [32:0] add_re2_r, add_im2_r;
  logic        eq2_r;

  assign sre_nxt = (op1_r == OP_MUL) ? ({p0_r[63], p0_r} - {p1_r[63], p1_r})
                                     : ({p0_r[63], p0_r} + {p1_r[63], p1_r});
  assign sim_nxt = (op1_r == OP_MUL) ? ({p2_r[63], p2_r} + {p3_r[63], p3_r})
                                     : ({p3_r[63], p3_r} - {p2_r[63], p2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    op2_r     <= op1_r;
    sre2_r    <= sre_nxt;
    sim2_r    <= sim_nxt;
    ssq2_r    <= q0_r + q1_r;
    add_re2_r <= add_re1_r;
    add_im2_r <= add_im1_r;
    eq2_r     <= eq1_r;
  end

  // stage 3
  logic signed [64:0] mre, mim;
  logic [32:0]        sat_re, sat_im, sat_add_re, sat_add_im;
  logic               dz;
  cau_work_t          work_nxt;
  logic               v3_r;
  cau_work_t          work_r;

  assign mre        = $signed(sre2_r) >>> FRAC_BITS;
  assign mim        = $signed(sim2_r) >>> FRAC_BITS;
  assign sat_re     = sat_wide(mre);
  assign sat_im     = sat_wide(mim);
  assign sat_add_re = sat_wide({{32{add_re2_r[32]}}, add_re2_r});
  assign sat_add_im = sat_wide({{32{add_im2_r[32]}}, add_im2_r});
  assign dz         = (ssq2_r == '0);

  always_comb begin
    work_nxt          = '0;
    work_nxt.den      = ssq2_r;
    work_nxt.re       = lane_init(sre2_r, ssq2_r);
    work_nxt.im       = lane_init(sim2_r, ssq2_r);
    work_nxt.sq_src   = {2'b00, ssq2_r};
    work_nxt.use_div  = (op2_r == OP_DIV) && !dz;
    work_nxt.use_sqrt = (op2_r == OP_MAG);
    unique case (op2_r)
      OP_ADD, OP_SUB: begin
        work_nxt.fix_re  = sat_add_re[31:0];
        work_nxt.fix_im  = sat_add_im[31:0];
        work_nxt.fix_ovf = sat_add_re[32] | sat_add_im[32];
      end
      OP_MUL: begin
        work_nxt.fix_re  = sat_re[31:0];
        work_nxt.fix_im  = sat_im[31:0];
        work_nxt.fix_ovf = sat_re[32] | sat_im[32];
      end
      OP_DIV: work_nxt.fix_dz = dz;
      OP_EQ:  work_nxt.fix_eq = eq2_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work_vld = v3_r;
  assign work     = work_r;

endmodule

[sv/cau_step.sv]
// ---------------------------------------------------------------------------
// cau_step
// one quotient bit for both divider lanes and one root bit per stage
// ---------------------------------------------------------------------------
module cau_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cau_pkg::cau_work_t in_work,
  output logic               out_vld,
  output cau_pkg::cau_work_t out_work
);
  import cau_pkg::*;

  function automatic cau_lane_t lane_step(input cau_lane_t l, input logic [63:0] den);
    cau_lane_t   n;
    logic [64:0] t;
    n = l;
    t = {l.rem, l.lo[32]};
    n.lo = {l.lo[31:0], 1'b0};
    if (t >= {1'b0, den}) begin
      n.rem = 64'(t - {1'b0, den});
      n.q   = {l.q[31:0], 1'b1};
    end else begin
      n.rem = t[63:0];
      n.q   = {l.q[31:0], 1'b0};
    end
    return n;
  endfunction

  logic [35:0] sq_t, sq_trial;
  cau_work_t   work_nxt;
  logic        vld_r;
  cau_work_t   work_r;

  assign sq_t     = {in_work.sq_rem[33:0], in_work.sq_src[65:64]};
  assign sq_trial = {2'b00, in_work.sq_root, 2'b01};

  always_comb begin
    work_nxt        = in_work;
    work_nxt.re     = lane_step(in_work.re, in_work.den);
    work_nxt.im     = lane_step(in_work.im, in_work.den);
    work_nxt.sq_src = {in_work.sq_src[63:0], 2'b00};
    if (sq_t >= sq_trial) begin
      work_nxt.sq_rem  = sq_t - sq_trial;
      work_nxt.sq_root = {in_work.sq_root[30:0], 1'b1};
    end else begin
      work_nxt.sq_rem  = sq_t;
      work_nxt.sq_root = {in_work.sq_root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign out_vld  = vld_r;
  assign out_work = work_r;

endmodule

[sv/cau_back.sv]
// ---------------------------------------------------------------------------
// cau_back
// quotient rounding and saturation, root clamp, result select and register
// ---------------------------------------------------------------------------
module cau_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cau_pkg::cau_work_t in_work,
  output logic               res_vld,
  output logic [31:0]        res_re,
  output logic [31:0]        res_im,
  output logic               res_eq,
  output logic               res_dz,
  output logic               res_ovf
);
  import cau_pkg::*;

  function automatic logic [32:0] lane_done(input cau_lane_t l);
    logic [33:0] m;
    m = {1'b0, l.q} + {33'd0, (l.neg && (l.rem != '0))};
    if (l.big) return {1'b1, l.neg ? SAT_MIN : SAT_MAX};
    if (!l.neg) begin
      if (m > {2'b00, SAT_MAX}) return {1'b1, SAT_MAX};
      return {1'b0, m[31:0]};
    end
    if (m > {2'b00, SAT_MIN}) return {1'b1, SAT_MIN};
    return {1'b0, ~m[31:0] + 32'd1};
  endfunction

  logic [32:0] dre, dim;
  logic [31:0] re_nxt, im_nxt;
  logic        eq_nxt, dz_nxt, ovf_nxt;
  logic        vld_r;
  logic [31:0] re_r, im_r;
  logic        eq_r, dz_r, ovf_r;

  assign dre = lane_done(in_work.re);
  assign dim = lane_done(in_work.im);

  always_comb begin
    priority if (in_work.use_div) begin
      re_nxt  = dre[31:0];
      im_nxt  = dim[31:0];
      eq_nxt  = 1'b0;
      dz_nxt  = 1'b0;
      ovf_nxt = dre[32] | dim[32];
    end else if (in_work.use_sqrt) begin
      re_nxt  = in_work.sq_root[31] ? SAT_MAX : in_work.sq_root;
      im_nxt  = '0;
      eq_nxt  = 1'b0;
      dz_nxt  = 1'b0;
      ovf_nxt = in_work.sq_root[31];
    end else begin
      re_nxt  = in_work.fix_re;
      im_nxt  = in_work.fix_im;
      eq_nxt  = in_work.fix_eq;
      dz_nxt  = in_work.fix_dz;
      ovf_nxt = in_work.fix_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    eq_r  <= eq_nxt;
    dz_r  <= dz_nxt;
    ovf_r <= ovf_nxt;
  end

  assign res_vld = vld_r;
  assign res_re  = re_r;
  assign res_im  = im_r;
  assign res_eq  = eq_r;
  assign res_dz  = dz_r;
  assign res_ovf = ovf_r;

endmodule

[sv/complex_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply, divide, magnitude and compare
// on signed fixed point operands
// ---------------------------------------------------------------------------
//   channel  handshake            beat
//   in       start / busy         in_operation, in_a_re, in_a_im, in_b_re, in_b_im
//   out      out_valid strobe     out_res_re, out_res_im, out_is_equal,
//                                 out_div_zero, out_overflowed
//
// one beat accepted per cycle, busy stays low
// pipeline from accept edge to result edge: 4 setup stages,
// 33 restoring divide / root stages, 1 output
// the 33-stage one-bit-per-stage divider sets the depth
// synchronous reset clears all valid bits, nothing is in flight afterward
// results are shown for one cycle and are never held
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_valid,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_is_equal,
  output logic               out_div_zero,
  output logic               out_overflowed
);
  import cau_pkg::*;
  `include "complex_arithmetic_unit_assert.svh"

  logic      vld [CAU_DIV_STEPS+1];
  cau_work_t work [CAU_DIV_STEPS+1];

  assign busy = 1'b0;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_operation),
    .a_re    (in_a_re),
    .a_im    (in_a_im),
    .b_re    (in_b_re),
    .b_im    (in_b_im),
    .work_vld(vld[0]),
    .work    (work[0])
  );

  for (genvar i = 0; i < CAU_DIV_STEPS; i++) begin : g_step
    cau_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[i]),
      .in_work (work[i]),
      .out_vld (vld[i+1]),
      .out_work(work[i+1])
    );
  end

  cau_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (vld[CAU_DIV_STEPS]),
    .in_work(work[CAU_DIV_STEPS]),
    .res_vld(out_valid),
    .res_re (out_res_re),
    .res_im (out_res_im),
    .res_eq (out_is_equal),
    .res_dz (out_div_zero),
    .res_ovf(out_overflowed)
  );

  `CAU_CHECK(a_dz_no_ovf, out_valid, !(out_div_zero && out_overflowed), "div zero with overflow")
  `CAU_CHECK(a_dz_zero, out_valid && out_div_zero, (out_res_re == '0) && (out_res_im == '0), "div zero result not zero")
  `CAU_CHECK(a_eq_clean, out_valid && out_is_equal, (out_res_re == '0) && (out_res_im == '0) && !out_overflowed && !out_div_zero, "equal beat carries data")
  `CAU_CHECK_NEXT(a_busy_low, 1'b1, !busy, "busy raised")

endmodule
